/* src/mesh_torus_route_generator_assert.svh */
// Assertion macros for the route generator. Each use needs clk and arst_n in scope.
`ifndef MESH_TORUS_ROUTE_GENERATOR_ASSERT_SVH
`define MESH_TORUS_ROUTE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MTRG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("route generator: same-cycle check failed");

// next-cycle implication
`define MTRG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("route generator: next-cycle check failed");

`else

`define MTRG_ASSERT_IMP(lbl, ante, cons)
`define MTRG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/mtrg_pkg.sv */
package mtrg_pkg;

	// grid geometry
	localparam int MAX_SIDE = 8;
	localparam int SIDE_MIN = 3;
	localparam int SIDE_CAP = (MAX_SIDE < 8) ? MAX_SIDE : 8;
	localparam int SIDE_W   = 4;
	localparam int COORD_W  = $clog2(SIDE_CAP);
	localparam int NODE_W   = 6;
	localparam int HOP_W    = 7;
	localparam int PORT_W   = 4;
	localparam int KIND_W   = 2;

	localparam logic [HOP_W-1:0] SWITCH_BASE = 7'd64;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE = 1'd1;

	// route kinds
	localparam logic [KIND_W-1:0] KIND_MESH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RING = 2'd1;

	// output port codes
	localparam logic [PORT_W-1:0] PORT_PLUS_X  = 4'd0;
	localparam logic [PORT_W-1:0] PORT_PLUS_Y  = 4'd2;
	localparam logic [PORT_W-1:0] PORT_RING_FW = 4'd4;
	localparam logic [PORT_W-1:0] PORT_UPLINK  = 4'd6;
	localparam logic [PORT_W-1:0] PORT_DOWN    = 4'd7;
	localparam logic [PORT_W-1:0] PORT_EJECT   = 4'd8;

	// which word the datapath loads into the output register
	localparam int EMIT_W = 3;
	localparam logic [EMIT_W-1:0] EMIT_BAD    = 3'd0;
	localparam logic [EMIT_W-1:0] EMIT_WALK_X = 3'd1;
	localparam logic [EMIT_W-1:0] EMIT_WALK_Y = 3'd2;
	localparam logic [EMIT_W-1:0] EMIT_UP     = 3'd3;
	localparam logic [EMIT_W-1:0] EMIT_DOWN   = 3'd4;
	localparam logic [EMIT_W-1:0] EMIT_EJECT  = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic              div_step;
		logic              setup;
		logic              x_step;
		logic              y_step;
		logic              emit;
		logic [EMIT_W-1:0] emit_sel;
	} mtrg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;
		logic switch_kind;
		logic x_done;
		logic y_done;
		logic out_free;
	} mtrg_sts_t;

endpackage

/* src/mtrg_datapath.sv */
module mtrg_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [mtrg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mtrg_pkg::CFG_DAT_W-1:0]       cfg_data,
	input  logic [mtrg_pkg::KIND_W-1:0]          kind,
	input  logic [mtrg_pkg::NODE_W-1:0]          src_node,
	input  logic [mtrg_pkg::NODE_W-1:0]          dest_node,
	input  mtrg_pkg::mtrg_cmd_t                  cmd,
	output mtrg_pkg::mtrg_sts_t                  sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mtrg_pkg::HOP_W-1:0]           hop_node,
	output logic [mtrg_pkg::PORT_W-1:0]          out_port,
	output logic                                 bad_request,
	output logic                                 last_hop
);
	import mtrg_pkg::*;

	// forward distance from cur to tgt around a ring of s nodes
	function automatic logic [SIDE_W-1:0] fwd_dist(input logic [COORD_W-1:0] cur,
			input logic [COORD_W-1:0] tgt, input logic [SIDE_W-1:0] s);
		logic [SIDE_W:0] sum;
		sum = (SIDE_W+1)'(tgt) + (SIDE_W+1)'(s) - (SIDE_W+1)'(cur);
		if (sum >= (SIDE_W+1)'(s)) sum = sum - (SIDE_W+1)'(s);
		return sum[SIDE_W-1:0];
	endfunction

	// 0 forward, 1 backward
	function automatic logic pick_dir(input logic [COORD_W-1:0] cur,
			input logic [COORD_W-1:0] tgt, input logic [SIDE_W-1:0] s,
			input logic tie_back, input logic wrap);
		logic [SIDE_W-1:0] fwd;
		logic [SIDE_W-1:0] bwd;
		fwd = fwd_dist(cur, tgt, s);
		bwd = s - fwd;
		if (!wrap) return !(tgt > cur);
		if (fwd < bwd) return 1'b0;
		if (bwd < fwd) return 1'b1;
		return tie_back;
	endfunction

	// one step along a dimension, wrapping at the edges
	function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] cur,
			input logic back, input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] last;
		last = s - SIDE_W'(1);
		if (back) return (cur == '0) ? last[COORD_W-1:0] : cur - COORD_W'(1);
		return (SIDE_W'(cur) == last) ? '0 : cur + COORD_W'(1);
	endfunction

	logic [SIDE_W-1:0]  grid_side_q;
	logic               wrap_q;
	logic [KIND_W-1:0]  kind_q;
	logic [NODE_W-1:0]  src_q;
	logic [NODE_W-1:0]  dst_q;
	logic [NODE_W-1:0]  rem_src_q;
	logic [NODE_W-1:0]  rem_dst_q;
	logic [NODE_W-1:0]  div_d_q;
	logic [COORD_W-1:0] walk_x_q;
	logic [COORD_W-1:0] walk_y_q;
	logic [COORD_W-1:0] tgt_x_q;
	logic [COORD_W-1:0] tgt_y_q;
	logic [1:0]         tie_q;
	logic               ring_back_q;
	logic               out_valid_q;
	logic [HOP_W-1:0]   hop_node_q;
	logic [PORT_W-1:0]  out_port_q;
	logic               bad_q;
	logic               last_q;

	logic [SIDE_W-1:0]   side;
	logic [2*SIDE_W-1:0] side_sq;
	logic                ge_src;
	logic                ge_dst;
	logic [SIDE_W-1:0]   ring_fwd;
	logic [SIDE_W-1:0]   ring_bwd;
	logic                ring_back;
	logic                x_back;
	logic                y_back;
	logic [HOP_W-1:0]    cur_node;
	logic [HOP_W-1:0]    d_node;
	logic [PORT_W-1:0]   d_port;
	logic                d_bad;
	logic                d_last;

	// effective side, clamped to the supported range
	always_comb begin
		if (grid_side_q < SIDE_W'(SIDE_MIN)) side = SIDE_W'(SIDE_MIN);
		else if (grid_side_q > SIDE_W'(SIDE_CAP)) side = SIDE_W'(SIDE_CAP);
		else side = grid_side_q;
	end

	assign side_sq = (2*SIDE_W)'(side) * (2*SIDE_W)'(side);

	// restoring divide step, one quotient bit per cycle for both ids
	assign ge_src = rem_src_q >= div_d_q;
	assign ge_dst = rem_dst_q >= div_d_q;

	// ring direction from the final remainders
	assign ring_fwd  = fwd_dist(rem_src_q[COORD_W-1:0], rem_dst_q[COORD_W-1:0], side);
	assign ring_bwd  = side - ring_fwd;
	assign ring_back = (ring_bwd < ring_fwd) || ((ring_bwd == ring_fwd) && src_q[0]);

	// direction of the next hop
	assign x_back = (kind_q == KIND_RING) ? ring_back_q
		: pick_dir(walk_x_q, tgt_x_q, side, tie_q[0], wrap_q);
	assign y_back = (kind_q == KIND_RING) ? !(tgt_y_q > walk_y_q)
		: pick_dir(walk_y_q, tgt_y_q, side, tie_q[1], wrap_q);

	assign cur_node = HOP_W'(walk_y_q) * HOP_W'(side) + HOP_W'(walk_x_q);

	// status
	assign sts.bad         = ((2*SIDE_W)'(src_q) >= side_sq) || ((2*SIDE_W)'(dst_q) >= side_sq);
	assign sts.switch_kind = kind_q[1];
	assign sts.x_done      = walk_x_q == tgt_x_q;
	assign sts.y_done      = walk_y_q == tgt_y_q;
	assign sts.out_free    = !out_valid_q || out_ready;

	// output word select
	always_comb begin
		d_node = '0;
		d_port = PORT_PLUS_X;
		d_bad  = 1'b0;
		d_last = 1'b0;
		case (cmd.emit_sel)
			EMIT_BAD: begin
				d_bad  = 1'b1;
				d_last = 1'b1;
			end
			EMIT_WALK_X: begin
				d_node = cur_node;
				d_port = (kind_q == KIND_RING) ? PORT_RING_FW + PORT_W'(x_back)
					: PORT_PLUS_X + PORT_W'(x_back);
			end
			EMIT_WALK_Y: begin
				d_node = cur_node;
				d_port = PORT_PLUS_Y + PORT_W'(y_back);
			end
			EMIT_UP: begin
				d_node = HOP_W'(src_q);
				d_port = PORT_UPLINK;
			end
			EMIT_DOWN: begin
				d_node = SWITCH_BASE + HOP_W'(kind_q[0]);
				d_port = PORT_DOWN;
			end
			EMIT_EJECT: begin
				d_node = HOP_W'(dst_q);
				d_port = PORT_EJECT;
				d_last = 1'b1;
			end
			default: begin
				d_node = '0;
			end
		endcase
	end

	// configuration registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_W'(8);
			wrap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_GRID_SIDE) grid_side_q <= cfg_data;
				if (cfg_index == REG_WRAP_ENABLE) wrap_q <= cfg_data[0];
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// request, walk and output payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			src_q     <= src_node;
			dst_q     <= dest_node;
			rem_src_q <= src_node;
			rem_dst_q <= dest_node;
			div_d_q   <= NODE_W'(side) << (COORD_W - 1);
			walk_y_q  <= '0;
			tgt_y_q   <= '0;
		end
		if (cmd.div_step) begin
			if (ge_src) rem_src_q <= rem_src_q - div_d_q;
			if (ge_dst) rem_dst_q <= rem_dst_q - div_d_q;
			walk_y_q <= {walk_y_q[COORD_W-2:0], ge_src};
			tgt_y_q  <= {tgt_y_q[COORD_W-2:0], ge_dst};
			div_d_q  <= div_d_q >> 1;
		end
		if (cmd.setup) begin
			walk_x_q    <= rem_src_q[COORD_W-1:0];
			tgt_x_q     <= rem_dst_q[COORD_W-1:0];
			tie_q       <= {walk_y_q[0], rem_src_q[0]};
			ring_back_q <= ring_back;
		end
		if (cmd.x_step) walk_x_q <= step_coord(walk_x_q, x_back, side);
		if (cmd.y_step) walk_y_q <= step_coord(walk_y_q, y_back, side);
		if (cmd.emit) begin
			hop_node_q <= d_node;
			out_port_q <= d_port;
			bad_q      <= d_bad;
			last_q     <= d_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign hop_node    = hop_node_q;
	assign out_port    = out_port_q;
	assign bad_request = bad_q;
	assign last_hop    = last_q;

endmodule

/* src/mtrg_ctrl.sv */
`include "mesh_torus_route_generator_assert.svh"

module mtrg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mtrg_pkg::mtrg_sts_t sts,
	output mtrg_pkg::mtrg_cmd_t cmd
);
	import mtrg_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] S_CHECK = 4'd1;
	localparam logic [ST_W-1:0] S_DIV   = 4'd2;
	localparam logic [ST_W-1:0] S_SETUP = 4'd3;
	localparam logic [ST_W-1:0] S_WALKX = 4'd4;
	localparam logic [ST_W-1:0] S_WALKY = 4'd5;
	localparam logic [ST_W-1:0] S_EJECT = 4'd6;
	localparam logic [ST_W-1:0] S_UP    = 4'd7;
	localparam logic [ST_W-1:0] S_DOWN  = 4'd8;

	localparam int CNT_W = $clog2(COORD_W);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(COORD_W - 1);

	logic [ST_W-1:0]  state_q;
	logic [ST_W-1:0]  state_d;
	logic [CNT_W-1:0] div_cnt_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.bad) begin
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_BAD;
						state_d      = S_IDLE;
					end
				end else if (sts.switch_kind) begin
					state_d = S_UP;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) state_d = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_WALKX;
			end
			S_WALKX: begin
				if (sts.x_done) begin
					state_d = S_WALKY;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_WALK_X;
					cmd.x_step   = 1'b1;
				end
			end
			S_WALKY: begin
				if (sts.y_done) begin
					state_d = S_EJECT;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_WALK_Y;
					cmd.y_step   = 1'b1;
				end
			end
			S_UP: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_UP;
					state_d      = S_DOWN;
				end
			end
			S_DOWN: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_DOWN;
					state_d      = S_EJECT;
				end
			end
			S_EJECT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_EJECT;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and divide step counter, back to zero on the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV && div_cnt_q != DIV_LAST) div_cnt_q <= div_cnt_q + CNT_W'(1);
			else div_cnt_q <= '0;
		end
	end

	`MTRG_ASSERT_NEXT(a_load_goes_check, in_valid && in_ready, state_q == S_CHECK)
	`MTRG_ASSERT_IMP(a_emit_has_room, cmd.emit, sts.out_free)
	`MTRG_ASSERT_IMP(a_cnt_only_in_div, div_cnt_q != '0, state_q == S_DIV)
	`MTRG_ASSERT_NEXT(a_eject_ends_route, cmd.emit && (cmd.emit_sel == EMIT_EJECT),
		state_q == S_IDLE)

endmodule

/* src/mesh_torus_route_generator.sv */
// channel   handshake             word
// -------   -------------------   --------------------------------------------
// request   in_valid / in_ready   kind, src_node, dest_node
// hop       out_valid / out_ready hop_node, out_port, bad_request, last_hop
// config    cfg_wr_en             cfg_index, cfg_data (no wait, no read-back)
//
// Grid route of hx + hy hops: load, range check, shared divider, setup, then the
// controller walks one hop per cycle while the output register is free, then ejects.
// Switch route: uplink, down and eject words. Out-of-range ids: one bad word.
// Reset: side 8, no wraparound, controller idle, output register empty.
// A stalled output holds the walk; a new request is taken once the last word
// sits in the output register.
module mesh_torus_route_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mtrg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mtrg_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mtrg_pkg::KIND_W-1:0]        kind,
	input  logic [mtrg_pkg::NODE_W-1:0]        src_node,
	input  logic [mtrg_pkg::NODE_W-1:0]        dest_node,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mtrg_pkg::HOP_W-1:0]         hop_node,
	output logic [mtrg_pkg::PORT_W-1:0]        out_port,
	output logic                               bad_request,
	output logic                               last_hop
);
	import mtrg_pkg::*;

	mtrg_cmd_t cmd;
	mtrg_sts_t sts;

	mtrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtrg_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.src_node    (src_node),
		.dest_node   (dest_node),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hop_node    (hop_node),
		.out_port    (out_port),
		.bad_request (bad_request),
		.last_hop    (last_hop)
	);

endmodule
